// ===== hw/rtl/ps2mct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mct_pkg
// Shared types, widths, codes and helpers of the mouse packet cursor tracker.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

    localparam int COORD_WIDTH     = 12;
    localparam int SCREEN_WIDTH    = 12;
    localparam int CURSOR_WIDTH    = 12;
    localparam int BUTTON_WIDTH    = 3;
    localparam int DELTA_WIDTH     = 10;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 12;
    localparam int WIDE_WIDTH      =
        ((COORD_WIDTH > SCREEN_WIDTH) ? COORD_WIDTH : SCREEN_WIDTH) + 2;

    typedef logic [COORD_WIDTH-1:0]         coord_t;
    typedef logic [SCREEN_WIDTH-1:0]        screen_t;
    typedef logic [CURSOR_WIDTH-1:0]        cursor_t;
    typedef logic [BUTTON_WIDTH-1:0]        button_t;
    typedef logic signed [DELTA_WIDTH-1:0]  delta_t;
    typedef logic signed [WIDE_WIDTH-1:0]   wide_t;
    typedef logic [CFG_INDEX_WIDTH-1:0]     cfg_index_t;
    typedef logic [CFG_DATA_WIDTH-1:0]      cfg_data_t;

    localparam coord_t     COORD_MAX          = '1;
    localparam screen_t    SCREEN_WIDTH_RST   = SCREEN_WIDTH'(1024);
    localparam screen_t    SCREEN_HEIGHT_RST  = SCREEN_WIDTH'(768);
    localparam cfg_index_t REG_SCREEN_WIDTH   = CFG_INDEX_WIDTH'(0);
    localparam cfg_index_t REG_SCREEN_HEIGHT  = CFG_INDEX_WIDTH'(1);

    localparam int SYNC_BIT   = 3;
    localparam int SIGN_X_BIT = 4;
    localparam int SIGN_Y_BIT = 5;

    // packet byte phase
    typedef enum logic [2:0] {
        PH_FLAGS = 3'b001,
        PH_DX    = 3'b010,
        PH_DY    = 3'b100
    } phase_t;

    // decoded packet from assembler to tracker
    typedef struct packed {
        logic    done;
        button_t buttons;
        delta_t  dx;
        delta_t  dy;
    } pkt_t;

    // next cursor state from tracker
    typedef struct packed {
        coord_t  x;
        coord_t  y;
        button_t buttons;
    } cursor_state_t;

    function automatic coord_t limit_of(screen_t s);
        if (wide_t'({1'b0, s}) > wide_t'({1'b0, COORD_MAX}))
            return COORD_MAX;
        return coord_t'(s);
    endfunction

    function automatic coord_t clamp_move(coord_t pos, delta_t d, coord_t hi);
        wide_t sum;
        sum = wide_t'({1'b0, pos}) + wide_t'(d);
        if (sum < 0)
            return '0;
        if (sum > wide_t'({1'b0, hi}))
            return hi;
        return coord_t'(sum);
    endfunction

endpackage

// ===== hw/rtl/ps2mct_byte_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mct_byte_if
// Request channel carrying one controller byte with its status flags.
// ----------------------------------------------------------------------------
interface ps2mct_byte_if;
    logic       valid;
    logic       ready;
    logic       has_data;
    logic       from_aux;
    logic [7:0] data_byte;

    modport source (output valid, output has_data, output from_aux, output data_byte,
                    input ready);
    modport sink   (input valid, input has_data, input from_aux, input data_byte,
                    output ready);
endinterface

// ===== hw/rtl/ps2mct_cursor_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mct_cursor_if
// Result channel carrying cursor position, buttons and packet completion.
// ----------------------------------------------------------------------------
interface ps2mct_cursor_if;
    logic                      valid;
    logic                      ready;
    ps2mct_pkg::cursor_t       cursor_x;
    ps2mct_pkg::cursor_t       cursor_y;
    ps2mct_pkg::button_t       button_bits;
    logic                      packet_done;

    modport source (output valid, output cursor_x, output cursor_y,
                    output button_bits, output packet_done, input ready);
    modport sink   (input valid, input cursor_x, input cursor_y,
                    input button_bits, input packet_done, output ready);
endinterface

// ===== hw/rtl/ps2mct_assembler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mct_assembler
// Gathers mouse bytes into three-byte packets and decodes buttons and deltas.
// ----------------------------------------------------------------------------
module ps2mct_assembler
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        data_byte,
    output ps2mct_pkg::pkt_t  pkt
);

    ps2mct_pkg::phase_t phase_reg;
    ps2mct_pkg::phase_t phase_next;
    logic [7:0]         flags_reg;
    logic [7:0]         flags_next;
    logic [7:0]         dx_byte_reg;
    logic [7:0]         dx_byte_next;

    always_comb
    begin
        phase_next   = phase_reg;
        flags_next   = flags_reg;
        dx_byte_next = dx_byte_reg;
        if (take)
        begin
            case (phase_reg)
                ps2mct_pkg::PH_FLAGS:
                begin
                    if (data_byte[ps2mct_pkg::SYNC_BIT])
                    begin
                        flags_next = data_byte;
                        phase_next = ps2mct_pkg::PH_DX;
                    end
                end
                ps2mct_pkg::PH_DX:
                begin
                    dx_byte_next = data_byte;
                    phase_next   = ps2mct_pkg::PH_DY;
                end
                ps2mct_pkg::PH_DY:
                begin
                    phase_next = ps2mct_pkg::PH_FLAGS;
                end
                default:
                begin
                    phase_next = ps2mct_pkg::PH_FLAGS;
                end
            endcase
        end
    end

    // sign bit in flags subtracts 256, dy is flipped so up decreases
    always_comb
    begin
        pkt.done    = take && (phase_reg == ps2mct_pkg::PH_DY);
        pkt.buttons = flags_reg[ps2mct_pkg::BUTTON_WIDTH-1:0];
        pkt.dx      = ps2mct_pkg::delta_t'($signed({flags_reg[ps2mct_pkg::SIGN_X_BIT],
                                                    dx_byte_reg}));
        pkt.dy      = -ps2mct_pkg::delta_t'($signed({flags_reg[ps2mct_pkg::SIGN_Y_BIT],
                                                     data_byte}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= ps2mct_pkg::PH_FLAGS;
        else
            phase_reg <= phase_next;
    end

    always_ff @(posedge clk)
    begin
        flags_reg   <= flags_next;
        dx_byte_reg <= dx_byte_next;
    end

    a_sync_required: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == ps2mct_pkg::PH_FLAGS && take && !data_byte[ps2mct_pkg::SYNC_BIT])
        |=> phase_reg == ps2mct_pkg::PH_FLAGS)
        else $error("packet started without sync bit");

    a_done_resets_phase: assert property (@(posedge clk) disable iff (!rst_n)
        pkt.done |=> phase_reg == ps2mct_pkg::PH_FLAGS)
        else $error("phase not back to flags after packet");

endmodule

// ===== hw/rtl/ps2mct_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mct_tracker
// Holds screen size and cursor state, applies packet deltas with clamping.
// ----------------------------------------------------------------------------
module ps2mct_tracker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  ps2mct_pkg::pkt_t              pkt,
    input  logic                          cfg_we,
    input  ps2mct_pkg::cfg_index_t        cfg_index,
    input  ps2mct_pkg::cfg_data_t         cfg_data,
    output ps2mct_pkg::cursor_state_t     state_next
);

    ps2mct_pkg::screen_t width_reg;
    ps2mct_pkg::screen_t width_next;
    ps2mct_pkg::screen_t height_reg;
    ps2mct_pkg::screen_t height_next;
    ps2mct_pkg::coord_t  pos_x_reg;
    ps2mct_pkg::coord_t  pos_y_reg;
    ps2mct_pkg::button_t buttons_reg;
    logic                recentre;
    ps2mct_pkg::screen_t cfg_screen;

    assign cfg_screen = ps2mct_pkg::screen_t'(cfg_data);

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        recentre    = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                ps2mct_pkg::REG_SCREEN_WIDTH:
                begin
                    width_next = cfg_screen;
                    recentre   = 1'b1;
                end
                ps2mct_pkg::REG_SCREEN_HEIGHT:
                begin
                    height_next = cfg_screen;
                    recentre    = 1'b1;
                end
                default:
                begin
                    recentre = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next.x       = pos_x_reg;
        state_next.y       = pos_y_reg;
        state_next.buttons = buttons_reg;
        if (fire && pkt.done)
        begin
            state_next.x       = ps2mct_pkg::clamp_move(pos_x_reg, pkt.dx,
                                                        ps2mct_pkg::limit_of(width_reg));
            state_next.y       = ps2mct_pkg::clamp_move(pos_y_reg, pkt.dy,
                                                        ps2mct_pkg::limit_of(height_reg));
            state_next.buttons = pkt.buttons;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= ps2mct_pkg::SCREEN_WIDTH_RST;
            height_reg  <= ps2mct_pkg::SCREEN_HEIGHT_RST;
            pos_x_reg   <= ps2mct_pkg::limit_of(ps2mct_pkg::SCREEN_WIDTH_RST >> 1);
            pos_y_reg   <= ps2mct_pkg::limit_of(ps2mct_pkg::SCREEN_HEIGHT_RST >> 1);
            buttons_reg <= '0;
        end
        else
        begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            buttons_reg <= state_next.buttons;
            if (recentre)
            begin
                pos_x_reg <= ps2mct_pkg::limit_of(width_next >> 1);
                pos_y_reg <= ps2mct_pkg::limit_of(height_next >> 1);
            end
            else
            begin
                pos_x_reg <= state_next.x;
                pos_y_reg <= state_next.y;
            end
        end
    end

    a_x_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
        ps2mct_pkg::wide_t'({1'b0, pos_x_reg}) <= ps2mct_pkg::wide_t'({1'b0, width_reg}))
        else $error("cursor x beyond screen width");

    a_y_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
        ps2mct_pkg::wide_t'({1'b0, pos_y_reg}) <= ps2mct_pkg::wide_t'({1'b0, height_reg}))
        else $error("cursor y beyond screen height");

endmodule

// ===== hw/rtl/ps2_mouse_packet_cursor_tracker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker_core
// Decodes three-byte mouse packets and tracks a clamped cursor position.
//
//   channel      dir  payload
//   byte_in      in   has_data, from_aux, data_byte
//   cursor_out   out  cursor_x, cursor_y, button_bits, packet_done
//   cfg          in   cfg_we, cfg_index, cfg_data (screen width, height)
//
// one byte accepted per cycle while byte_in.ready is high, result held in the output register
// every accepted byte yields one result, completed or not
// byte_in.ready drops only while a result is held and cursor_out.ready is low
// reset gives screen 1024x768 with the cursor centered and no buttons
// a screen size write recenters the cursor
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    ps2mct_byte_if.sink                 byte_in,
    ps2mct_cursor_if.source             cursor_out,
    input  logic                        cfg_we,
    input  ps2mct_pkg::cfg_index_t      cfg_index,
    input  ps2mct_pkg::cfg_data_t       cfg_data
);

    logic                          in_fire;
    logic                          take;
    ps2mct_pkg::pkt_t              pkt;
    ps2mct_pkg::cursor_state_t     state_next;
    logic                          out_valid_reg;
    ps2mct_pkg::cursor_t           cursor_x_reg;
    ps2mct_pkg::cursor_t           cursor_y_reg;
    ps2mct_pkg::button_t           buttons_reg;
    logic                          done_reg;

    assign byte_in.ready = !out_valid_reg || cursor_out.ready;
    assign in_fire       = byte_in.valid && byte_in.ready;
    assign take          = in_fire && byte_in.has_data && byte_in.from_aux;

    ps2mct_assembler u_assembler
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (byte_in.data_byte),
        .pkt       (pkt)
    );

    ps2mct_tracker u_tracker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (take),
        .pkt        (pkt),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .state_next (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (cursor_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cursor_x_reg <= ps2mct_pkg::cursor_t'(state_next.x);
            cursor_y_reg <= ps2mct_pkg::cursor_t'(state_next.y);
            buttons_reg  <= state_next.buttons;
            done_reg     <= pkt.done;
        end
    end

    assign cursor_out.valid       = out_valid_reg;
    assign cursor_out.cursor_x    = cursor_x_reg;
    assign cursor_out.cursor_y    = cursor_y_reg;
    assign cursor_out.button_bits = buttons_reg;
    assign cursor_out.packet_done = done_reg;

    a_result_from_request: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_fire))
        else $error("result appeared without an accepted request");

endmodule

// ===== tb/sv/ps2_mouse_packet_cursor_tracker_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker_core_tb
// Self-checking bench for the mouse packet cursor tracker. A queue of pending
// requests (controller bytes, screen size writes, drain points) feeds a
// negedge driver; a posedge monitor tracks the packet phase, buttons and
// clamped cursor itself and compares every result against its own forecast.
// Directed corner packets come first, then mostly well-formed random packets
// mixed with keyboard bytes, empty requests and broken packets over several
// screen sizes, with random stalls on both channels.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker_core_tb;

    import ps2mct_pkg::*;

    localparam cfg_index_t REG_SPARE_A   = CFG_INDEX_WIDTH'(2);
    localparam cfg_index_t REG_SPARE_B   = CFG_INDEX_WIDTH'(3);
    localparam int         SIGN_WEIGHT   = 256;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         IDLE_PCT      = 26;

    typedef enum {ITEM_BYTE, ITEM_CFG, ITEM_DRAIN, ITEM_STEADY} item_kind_e;

    typedef struct {
        item_kind_e kind;
        logic       has_data;
        logic       from_aux;
        logic [7:0] data;
        cfg_index_t idx;
        cfg_data_t  value;
    } stim_item_t;

    typedef struct packed {
        cursor_t x;
        cursor_t y;
        button_t buttons;
        logic    done;
    } cursor_rec_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    cfg_index_t cfg_index;
    cfg_data_t  cfg_data;

    ps2mct_byte_if   byte_ch ();
    ps2mct_cursor_if cursor_ch ();

    ps2_mouse_packet_cursor_tracker_core i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_ch),
        .cursor_out (cursor_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    stim_item_t  pending[$];
    cursor_rec_t cursor_due[$];
    int          mismatch_count = 0;
    int          settle = 0;
    logic        byte_fired = 1'b0;
    logic        no_idle = 1'b0;

    // tracker state mirrored by the bench
    screen_t     scr_w;
    screen_t     scr_h;
    coord_t      pos_x;
    coord_t      pos_y;
    button_t     held;
    phase_t      pkt_phase;
    logic [7:0]  flags_hold;
    logic [7:0]  dx_hold;

    function automatic int clip(input int v, input int hi);
        if (v < 0)
            return 0;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int screen_limit(input screen_t s);
        return (int'(s) > int'(COORD_MAX)) ? int'(COORD_MAX) : int'(s);
    endfunction

    function automatic void recenter_cursor();
        pos_x = coord_t'(clip(int'(scr_w) / 2, int'(COORD_MAX)));
        pos_y = coord_t'(clip(int'(scr_h) / 2, int'(COORD_MAX)));
    endfunction

    function automatic cursor_rec_t track_byte(input logic hd, input logic fa,
                                               input logic [7:0] b);
        cursor_rec_t r;
        int          dx;
        int          dy;
        r.done = 1'b0;
        if (hd && fa) begin
            case (pkt_phase)
                PH_FLAGS:
                    if (b[SYNC_BIT]) begin
                        flags_hold = b;
                        pkt_phase  = PH_DX;
                    end
                PH_DX:
                begin
                    dx_hold   = b;
                    pkt_phase = PH_DY;
                end
                default:
                begin
                    dx = int'(dx_hold) - (flags_hold[SIGN_X_BIT] ? SIGN_WEIGHT : 0);
                    dy = -(int'(b) - (flags_hold[SIGN_Y_BIT] ? SIGN_WEIGHT : 0));
                    pkt_phase = PH_FLAGS;
                    held      = flags_hold[BUTTON_WIDTH-1:0];
                    pos_x     = coord_t'(clip(int'(pos_x) + dx, screen_limit(scr_w)));
                    pos_y     = coord_t'(clip(int'(pos_y) + dy, screen_limit(scr_h)));
                    r.done    = 1'b1;
                end
            endcase
        end
        r.x       = cursor_t'(pos_x);
        r.y       = cursor_t'(pos_y);
        r.buttons = held;
        return r;
    endfunction

    // ------------------------------------------------------------------ stimulus

    task automatic push_byte(input logic hd, input logic fa, input logic [7:0] b);
        stim_item_t it;
        it.kind     = ITEM_BYTE;
        it.has_data = hd;
        it.from_aux = fa;
        it.data     = b;
        it.idx      = REG_SCREEN_WIDTH;
        it.value    = '0;
        pending.push_back(it);
    endtask

    task automatic push_ctrl(input item_kind_e kind, input cfg_index_t idx,
                             input cfg_data_t value);
        stim_item_t it;
        it.kind     = kind;
        it.has_data = 1'b0;
        it.from_aux = 1'b0;
        it.data     = '0;
        it.idx      = idx;
        it.value    = value;
        pending.push_back(it);
    endtask

    task automatic push_packet(input logic [7:0] f, input logic [7:0] x,
                               input logic [7:0] y);
        push_byte(1'b1, 1'b1, f);
        push_byte(1'b1, 1'b1, x);
        push_byte(1'b1, 1'b1, y);
    endtask

    task automatic push_screen(input cfg_data_t w, input cfg_data_t h);
        push_ctrl(ITEM_DRAIN, REG_SCREEN_WIDTH, '0);
        push_ctrl(ITEM_CFG, REG_SCREEN_WIDTH, w);
        push_ctrl(ITEM_CFG, REG_SCREEN_HEIGHT, h);
    endtask

    function automatic logic [7:0] pick_delta();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic queue_traffic(input int aux_bytes);
        int         sent;
        int         pick;
        int         n;
        logic [7:0] pkt [3];
        sent = 0;
        while (sent < aux_bytes) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                push_byte(1'b0, 1'($urandom_range(1)), 8'($urandom));
            end else if (pick < 12) begin
                push_byte(1'b1, 1'b0, 8'($urandom));
            end else if (pick < 17) begin
                push_byte(1'b1, 1'b1, 8'($urandom));
                sent++;
            end else begin
                pkt[0] = 8'($urandom) | (8'h01 << SYNC_BIT);
                pkt[1] = pick_delta();
                pkt[2] = pick_delta();
                // cut the packet short now and then
                n = (pick < 20) ? $urandom_range(1, 2) : 3;
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(19) == 0)
                        push_byte(1'b1, 1'b0, 8'($urandom));
                    push_byte(1'b1, 1'b1, pkt[i]);
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------ clock, reset, run

    initial begin
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = REG_SCREEN_WIDTH;
        cfg_data              = '0;
        byte_ch.valid         = 1'b0;
        byte_ch.has_data      = 1'b0;
        byte_ch.from_aux      = 1'b0;
        byte_ch.data_byte     = '0;
        cursor_ch.ready       = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        // empty and keyboard requests, bytes that cannot start a packet
        push_byte(1'b0, 1'b0, 8'hFF);
        push_byte(1'b0, 1'b1, 8'h08);
        push_byte(1'b1, 1'b0, 8'h08);
        push_byte(1'b1, 1'b1, 8'h00);
        push_byte(1'b1, 1'b1, 8'hF7);
        // largest moves both ways and sign handling
        push_packet(8'h08, 8'hFF, 8'h00);
        push_packet(8'h18, 8'h00, 8'hFF);
        push_byte(1'b1, 1'b1, 8'h2F);
        push_byte(1'b1, 1'b1, 8'h01);
        push_byte(1'b1, 1'b0, 8'h55);
        push_byte(1'b0, 1'b1, 8'hAA);
        push_byte(1'b1, 1'b1, 8'h00);
        push_packet(8'h3F, 8'h80, 8'h80);
        push_packet(8'hC8, 8'h7F, 8'h7F);
        push_packet(8'hFF, 8'hFF, 8'hFF);
        queue_traffic(200);

        push_screen(cfg_data_t'(4095), cfg_data_t'(4095));
        queue_traffic(250);

        push_screen(cfg_data_t'(0), cfg_data_t'(0));
        queue_traffic(150);

        push_ctrl(ITEM_DRAIN, REG_SCREEN_WIDTH, '0);
        push_ctrl(ITEM_CFG, REG_SPARE_A, cfg_data_t'($urandom));
        push_ctrl(ITEM_CFG, REG_SPARE_B, cfg_data_t'($urandom));
        push_ctrl(ITEM_CFG, REG_SCREEN_WIDTH, cfg_data_t'(1));
        push_ctrl(ITEM_CFG, REG_SCREEN_HEIGHT, cfg_data_t'(2));
        push_ctrl(ITEM_STEADY, REG_SCREEN_WIDTH, cfg_data_t'(1));
        queue_traffic(250);
        push_ctrl(ITEM_STEADY, REG_SCREEN_WIDTH, cfg_data_t'(0));

        push_screen(cfg_data_t'($urandom), cfg_data_t'($urandom));
        queue_traffic(200);
        // hold off new requests until the tracker has caught up
        push_ctrl(ITEM_DRAIN, REG_SCREEN_WIDTH, '0);
        queue_traffic(150);

        push_ctrl(ITEM_DRAIN, REG_SCREEN_WIDTH, '0);
        push_ctrl(ITEM_CFG, REG_SPARE_B, cfg_data_t'(4095));
        push_ctrl(ITEM_CFG, REG_SCREEN_WIDTH, cfg_data_t'(16));
        push_ctrl(ITEM_CFG, REG_SCREEN_HEIGHT, cfg_data_t'(4095));
        push_ctrl(ITEM_CFG, REG_SPARE_A, cfg_data_t'(0));
        queue_traffic(200);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || byte_ch.valid || cursor_due.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        if (cursor_due.size() != 0) begin
            $display("%0t: %0d cursor results never arrived", $time, cursor_due.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("ps2_mouse_packet_cursor_tracker_core_tb OK");
        else
            $display("ps2_mouse_packet_cursor_tracker_core_tb NOT OK");
        $finish;
    end

    initial begin
        #400000;
        $display("%0t: timeout", $time);
        $display("ps2_mouse_packet_cursor_tracker_core_tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------ driver

    always @(negedge clk) begin
        logic       nv;
        logic       nhd;
        logic       nfa;
        logic [7:0] nbyte;
        logic       nwe;
        cfg_index_t nidx;
        cfg_data_t  nval;
        logic       nsteady;
        nv      = byte_ch.valid && !byte_fired;
        nhd     = byte_ch.has_data;
        nfa     = byte_ch.from_aux;
        nbyte   = byte_ch.data_byte;
        nwe     = 1'b0;
        nidx    = cfg_index;
        nval    = cfg_data;
        nsteady = no_idle;
        if (rst_n && !nv && pending.size() != 0) begin
            case (pending[0].kind)
                ITEM_BYTE:
                    if (no_idle || $urandom_range(99) >= IDLE_PCT) begin
                        nv    = 1'b1;
                        nhd   = pending[0].has_data;
                        nfa   = pending[0].from_aux;
                        nbyte = pending[0].data;
                        void'(pending.pop_front());
                    end
                ITEM_CFG:
                begin
                    nwe  = 1'b1;
                    nidx = pending[0].idx;
                    nval = pending[0].value;
                    void'(pending.pop_front());
                end
                ITEM_DRAIN:
                    if (cursor_due.size() == 0) begin
                        if (settle >= SETTLE_CYCLES) begin
                            settle = 0;
                            void'(pending.pop_front());
                        end else begin
                            settle++;
                        end
                    end
                default:
                begin
                    nsteady = pending[0].value[0];
                    void'(pending.pop_front());
                end
            endcase
        end
        byte_ch.valid     <= nv;
        byte_ch.has_data  <= nhd;
        byte_ch.from_aux  <= nfa;
        byte_ch.data_byte <= nbyte;
        cfg_we            <= nwe;
        cfg_index         <= nidx;
        cfg_data          <= nval;
        no_idle           <= nsteady;
    end

    always @(negedge clk)
        cursor_ch.ready <= rst_n && (no_idle || $urandom_range(99) >= IDLE_PCT);

    // ------------------------------------------------------------------ monitor

    always @(posedge clk) begin
        cursor_rec_t want;
        cursor_rec_t got;
        if (!rst_n) begin
            scr_w      = SCREEN_WIDTH_RST;
            scr_h      = SCREEN_HEIGHT_RST;
            held       = '0;
            pkt_phase  = PH_FLAGS;
            flags_hold = '0;
            dx_hold    = '0;
            byte_fired = 1'b0;
            recenter_cursor();
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_SCREEN_WIDTH) begin
                    scr_w = screen_t'(cfg_data);
                    recenter_cursor();
                end else if (cfg_index == REG_SCREEN_HEIGHT) begin
                    scr_h = screen_t'(cfg_data);
                    recenter_cursor();
                end
            end

            byte_fired = byte_ch.valid && byte_ch.ready;
            if (byte_fired)
                cursor_due.push_back(track_byte(byte_ch.has_data, byte_ch.from_aux,
                                                byte_ch.data_byte));

            if (cursor_ch.valid && cursor_ch.ready) begin
                got.x       = cursor_ch.cursor_x;
                got.y       = cursor_ch.cursor_y;
                got.buttons = cursor_ch.button_bits;
                got.done    = cursor_ch.packet_done;
                if (cursor_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got x %0d y %0d b %0d d %0d",
                             $time, got.x, got.y, got.buttons, got.done);
                    mismatch_count++;
                end else begin
                    want = cursor_due.pop_front();
                    if (got.x !== want.x) begin
                        $display("%0t: cursor_x expected %0d got %0d", $time, want.x, got.x);
                        mismatch_count++;
                    end
                    if (got.y !== want.y) begin
                        $display("%0t: cursor_y expected %0d got %0d", $time, want.y, got.y);
                        mismatch_count++;
                    end
                    if (got.buttons !== want.buttons) begin
                        $display("%0t: button_bits expected %0d got %0d",
                                 $time, want.buttons, got.buttons);
                        mismatch_count++;
                    end
                    if (got.done !== want.done) begin
                        $display("%0t: packet_done expected %0d got %0d",
                                 $time, want.done, got.done);
                        mismatch_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== sim.f =====
hw/rtl/ps2mct_pkg.sv
hw/rtl/ps2mct_byte_if.sv
hw/rtl/ps2mct_cursor_if.sv
hw/rtl/ps2mct_assembler.sv
hw/rtl/ps2mct_tracker.sv
hw/rtl/ps2_mouse_packet_cursor_tracker_core.sv
tb/sv/ps2_mouse_packet_cursor_tracker_core_tb.sv
